// File: sv/c8_pkg.sv
`default_nettype none
package c8_pkg;

    localparam int ADDR_W = 12;
    localparam logic [11:0] PROGRAM_BASE = 12'h200;
    localparam logic [11:0] GLYPH_BASE = 12'h050;
    localparam int GLYPH_BYTES = 80;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EXEC = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // memory port request from controller
    typedef struct packed {
        logic        rd_en;
        logic        wr_en;
        logic [11:0] addr;
        logic [7:0]  wdata;
    } mem_req_t;

    // controller to datapath command
    typedef enum logic [3:0] {
        DP_NONE      = 4'd0,
        DP_LATCH_IN  = 4'd1,
        DP_OP_HI     = 4'd2,
        DP_OP_LO     = 4'd3,
        DP_EXEC      = 4'd4,
        DP_CLEAR_ROW = 4'd5,
        DP_SPR_ROW   = 4'd6,
        DP_LOAD_REG  = 4'd7,
        DP_TICK      = 4'd8,
        DP_READ_ROW  = 4'd9,
        DP_SPR_FLAG  = 4'd10,
        DP_WR_MEM    = 4'd11
    } dp_cmd_t;

    typedef struct packed {
        dp_cmd_t     cmd;
        logic [4:0]  idx;
        logic [7:0]  mem_data;
    } dp_ctl_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] opcode;
        logic [11:0] index;
        logic [7:0]  vx_bcd;
        logic [7:0]  reg_k;
        logic [11:0] addr;
        logic [7:0]  wdata;
    } dp_stat_t;

    function automatic logic [7:0] glyph_byte(input logic [6:0] i);
        logic [7:0] g [0:GLYPH_BYTES-1];
        g = '{8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
              8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
              8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
              8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
              8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
              8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
              8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
              8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};
        if (i < 7'(GLYPH_BYTES)) begin
            return g[i];
        end
        return 8'h00;
    endfunction

endpackage
`default_nettype wire

// File: sv/c8_mem.sv
`default_nettype none
// 4 KiB byte memory; cleared and loaded with the font by a sweep after reset
module c8_mem (
    input  wire logic           aclk,
    input  wire c8_pkg::mem_req_t req,
    output logic [7:0]          rdata
);
    import c8_pkg::*;

    logic [7:0] mem [0:4095];

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.addr] <= req.wdata;
        end
        rdata <= mem[req.addr];
    end
endmodule
`default_nettype wire

// File: sv/c8_datapath.sv
`default_nettype none
module c8_datapath #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire c8_pkg::dp_ctl_t ctl,
    input  wire logic [1:0]      in_command,
    input  wire logic [11:0]     in_address,
    input  wire logic [7:0]      in_write_data,
    input  wire logic [15:0]     in_keys,
    input  wire logic [7:0]      in_random,
    input  wire logic [4:0]      in_row,
    output c8_pkg::dp_stat_t     stat,
    output logic [11:0]          pc_out,
    output logic [15:0]          op_out,
    output logic                 wait_out,
    output logic                 sound_out,
    output logic [63:0]          row_out
);
    import c8_pkg::*;

    localparam int SP_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [7:0]  v_reg [0:15];
    logic [11:0] stack_reg [0:STACK_DEPTH-1];
    logic [63:0] frame_reg [0:31];
    logic [11:0] pc_reg, index_reg;
    logic [SP_W-1:0] sp_reg;
    logic [SP_W-1:0] sp_dec;
    logic [7:0]  delay_reg, sound_reg;
    logic [15:0] op_reg, keys_reg;
    logic [7:0]  rnd_reg, wdata_reg;
    logic [11:0] addr_reg;
    logic [1:0]  cmd_reg;
    logic [4:0]  rowsel_reg;
    logic        wait_reg, hit_reg;
    logic [63:0] row_reg;

    logic [3:0] x, y;
    logic [7:0] vx, vy, kk;
    logic [5:0] xp;
    logic [4:0] srow;
    logic [63:0] spr;
    logic [127:0] spr_wide;
    logic [11:0] pc2;
    logic [4:0] first_key;
    logic       any_key;

    assign x  = op_reg[11:8];
    assign y  = op_reg[7:4];
    assign vx = v_reg[x];
    assign vy = v_reg[y];
    assign kk = op_reg[7:0];
    assign xp = vx[5:0];
    assign srow = vy[4:0] + ctl.idx;
    assign spr_wide = {ctl.mem_data, 120'd0} >> xp;
    assign spr = spr_wide[127:64] | spr_wide[63:0];
    assign pc2 = pc_reg + 12'd2;
    // stack pointer wraps to the top entry on underflow
    assign sp_dec = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    always_comb begin
        first_key = 5'd16;
        for (int k = 15; k >= 0; k--) begin
            if (keys_reg[k]) begin
                first_key = 5'(k);
            end
        end
    end
    assign any_key = ~first_key[4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PROGRAM_BASE;
            index_reg <= '0;
            sp_reg <= '0;
            delay_reg <= '0;
            sound_reg <= '0;
            wait_reg <= 1'b0;
            op_reg <= '0;
            row_reg <= '0;
            for (int i = 0; i < 16; i++) begin
                v_reg[i] <= '0;
            end
            for (int i = 0; i < 32; i++) begin
                frame_reg[i] <= '0;
            end
        end else begin
            case (ctl.cmd)
                DP_LATCH_IN: begin
                    cmd_reg <= in_command;
                    addr_reg <= in_address;
                    wdata_reg <= in_write_data;
                    keys_reg <= in_keys;
                    rnd_reg <= in_random;
                    rowsel_reg <= in_row;
                    op_reg <= '0;
                    wait_reg <= 1'b0;
                    row_reg <= '0;
                end
                DP_OP_HI: op_reg[15:8] <= ctl.mem_data;
                DP_OP_LO: begin
                    op_reg[7:0] <= ctl.mem_data;
                    pc_reg <= pc2;
                    hit_reg <= 1'b0;
                end
                DP_READ_ROW: row_reg <= frame_reg[rowsel_reg];
                DP_CLEAR_ROW: frame_reg[ctl.idx] <= '0;
                DP_SPR_ROW: begin
                    if ((frame_reg[srow] & spr) != 64'd0) begin
                        hit_reg <= 1'b1;
                    end
                    frame_reg[srow] <= frame_reg[srow] ^ spr;
                end
                DP_SPR_FLAG: v_reg[15] <= {7'd0, hit_reg};
                DP_LOAD_REG: v_reg[ctl.idx[3:0]] <= ctl.mem_data;
                DP_TICK: begin
                    if (delay_reg != 8'd0) delay_reg <= delay_reg - 8'd1;
                    if (sound_reg != 8'd0) sound_reg <= sound_reg - 8'd1;
                end
                DP_EXEC: begin
                    case (op_reg[15:12])
                        4'h0: begin
                            if (op_reg == 16'h00EE) begin
                                sp_reg <= sp_dec;
                                pc_reg <= stack_reg[sp_dec];
                            end
                        end
                        4'h1: pc_reg <= op_reg[11:0];
                        4'h2: begin
                            stack_reg[sp_reg] <= pc_reg;
                            sp_reg <= (sp_reg == SP_W'(STACK_DEPTH-1)) ? '0 : sp_reg + 1'b1;
                            pc_reg <= op_reg[11:0];
                        end
                        4'h3: if (vx == kk) pc_reg <= pc2;
                        4'h4: if (vx != kk) pc_reg <= pc2;
                        4'h5: if (vx == vy) pc_reg <= pc2;
                        4'h6: v_reg[x] <= kk;
                        4'h7: v_reg[x] <= vx + kk;
                        4'h8: begin
                            case (op_reg[3:0])
                                4'h0: v_reg[x] <= vy;
                                4'h1: v_reg[x] <= vx | vy;
                                4'h2: v_reg[x] <= vx & vy;
                                4'h3: v_reg[x] <= vx ^ vy;
                                4'h4: begin
                                    v_reg[x] <= vx + vy;
                                    v_reg[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'hFF};
                                end
                                4'h5: begin
                                    v_reg[x] <= vx - vy;
                                    v_reg[15] <= {7'd0, vx > vy};
                                end
                                4'h6: begin
                                    v_reg[x] <= {1'b0, vx[7:1]};
                                    v_reg[15] <= {7'd0, vx[0]};
                                end
                                4'h7: begin
                                    v_reg[x] <= vy - vx;
                                    v_reg[15] <= {7'd0, vy > vx};
                                end
                                4'hE: begin
                                    v_reg[x] <= {vx[6:0], 1'b0};
                                    v_reg[15] <= {7'd0, vx[7]};
                                end
                                default: ;
                            endcase
                        end
                        4'h9: if (vx != vy) pc_reg <= pc2;
                        4'hA: index_reg <= op_reg[11:0];
                        4'hB: pc_reg <= op_reg[11:0] + {4'd0, v_reg[0]};
                        4'hC: v_reg[x] <= rnd_reg & kk;
                        4'hD: ;
                        4'hE: begin
                            if ((kk == 8'h9E && keys_reg[vx[3:0]]) ||
                                (kk == 8'hA1 && !keys_reg[vx[3:0]])) begin
                                pc_reg <= pc2;
                            end
                        end
                        default: begin
                            case (kk)
                                8'h07: v_reg[x] <= delay_reg;
                                8'h0A: begin
                                    if (any_key) begin
                                        v_reg[x] <= {4'd0, first_key[3:0]};
                                    end else begin
                                        pc_reg <= pc_reg - 12'd2;
                                        wait_reg <= 1'b1;
                                    end
                                end
                                8'h15: delay_reg <= vx;
                                8'h18: sound_reg <= vx;
                                8'h1E: index_reg <= index_reg + {4'd0, vx};
                                8'h29: index_reg <= GLYPH_BASE
                                    + {6'd0, vx[3:0], 2'd0} + {8'd0, vx[3:0]};
                                default: ;
                            endcase
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign stat.command = cmd_reg;
    assign stat.opcode = op_reg;
    assign stat.index = index_reg;
    assign stat.vx_bcd = vx;
    assign stat.reg_k = v_reg[ctl.idx[3:0]];
    assign stat.addr = (cmd_reg == CMD_EXEC) ? pc_reg : addr_reg;
    assign stat.wdata = wdata_reg;

    assign pc_out = pc_reg;
    assign op_out = op_reg;
    assign wait_out = wait_reg;
    assign sound_out = (sound_reg != 8'd0);
    assign row_out = row_reg;
endmodule
`default_nettype wire

// File: sv/c8_ctrl.sv
`default_nettype none
module c8_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_fire,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    input  wire c8_pkg::dp_stat_t stat,
    input  wire logic [7:0]       mem_rdata,
    output c8_pkg::mem_req_t      mem_req,
    output c8_pkg::dp_ctl_t       ctl
);
    import c8_pkg::*;

    typedef enum logic [10:0] {
        ST_FONT  = 11'b00000000001,
        ST_IDLE  = 11'b00000000010,
        ST_DISP  = 11'b00000000100,
        ST_FHI   = 11'b00000001000,
        ST_FLO   = 11'b00000010000,
        ST_FWAIT = 11'b00000100000,
        ST_EXEC  = 11'b00001000000,
        ST_LOOP  = 11'b00010000000,
        ST_LOOPW = 11'b00100000000,
        ST_TICK  = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_t;

    typedef enum logic [2:0] {
        LP_NONE, LP_CLEAR, LP_SPRITE, LP_BCD, LP_SAVE, LP_LOAD
    } loop_t;

    state_t state_reg, state_next;
    loop_t  loop_reg, loop_next;
    logic [11:0] cnt_reg, cnt_next;
    logic [4:0]  lim_reg, lim_next;
    logic [7:0]  bcd;
    logic [7:0]  q10;
    logic [11:0] font_off;
    logic [3:0]  lo_n;

    // vx / 10 by reciprocal multiply, exact for every byte value
    assign q10 = 8'((16'(stat.vx_bcd) * 16'd205) >> 11);

    // per-digit bcd of vx, one digit per step
    always_comb begin
        case (cnt_reg[1:0])
            2'd0: bcd = (stat.vx_bcd >= 8'd200) ? 8'd2 : (stat.vx_bcd >= 8'd100) ? 8'd1 : 8'd0;
            2'd1: bcd = q10 - ((q10 >= 8'd20) ? 8'd20 : (q10 >= 8'd10) ? 8'd10 : 8'd0);
            default: bcd = stat.vx_bcd - 8'(q10 * 8'd10);
        endcase
    end
    assign lo_n = stat.opcode[3:0];
    assign font_off = cnt_reg - GLYPH_BASE;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FONT;
            loop_reg <= LP_NONE;
            cnt_reg <= '0;
            lim_reg <= '0;
        end else begin
            state_reg <= state_next;
            loop_reg <= loop_next;
            cnt_reg <= cnt_next;
            lim_reg <= lim_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        loop_next = loop_reg;
        cnt_next = cnt_reg;
        lim_next = lim_reg;
        mem_req = '0;
        ctl = '0;
        ctl.cmd = DP_NONE;
        ctl.mem_data = mem_rdata;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_FONT: begin
                // clear the whole memory and write the font bytes after reset
                mem_req.wr_en = 1'b1;
                mem_req.addr = cnt_reg;
                mem_req.wdata = (font_off < 12'(GLYPH_BYTES)) ? glyph_byte(font_off[6:0])
                                                              : 8'h00;
                cnt_next = cnt_reg + 12'd1;
                if (cnt_reg == 12'hFFF) begin
                    state_next = ST_IDLE;
                    cnt_next = '0;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_fire) begin
                    ctl.cmd = DP_LATCH_IN;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                case (stat.command)
                    CMD_WRITE: begin
                        mem_req.wr_en = 1'b1;
                        mem_req.addr = stat.addr;
                        mem_req.wdata = stat.wdata;
                        state_next = ST_OUT;
                    end
                    CMD_EXEC: begin
                        mem_req.addr = stat.addr;
                        state_next = ST_FHI;
                    end
                    CMD_READ: begin
                        ctl.cmd = DP_READ_ROW;
                        state_next = ST_OUT;
                    end
                    default: state_next = ST_OUT;
                endcase
            end
            ST_FHI: begin
                ctl.cmd = DP_OP_HI;
                mem_req.addr = stat.addr + 12'd1;
                state_next = ST_FLO;
            end
            ST_FLO: begin
                ctl.cmd = DP_OP_LO;
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                cnt_next = '0;
                state_next = ST_TICK;
                loop_next = LP_NONE;
                if (stat.opcode == 16'h00E0) begin
                    loop_next = LP_CLEAR; lim_next = 5'd31; state_next = ST_LOOP;
                end else if (stat.opcode[15:12] == 4'hD) begin
                    if (lo_n == 4'd0) begin
                        ctl.cmd = DP_SPR_FLAG;
                    end else begin
                        loop_next = LP_SPRITE; lim_next = 5'(lo_n - 4'd1); state_next = ST_LOOP;
                    end
                end else if (stat.opcode[15:12] == 4'hF && stat.opcode[7:0] == 8'h33) begin
                    loop_next = LP_BCD; lim_next = 5'd2; state_next = ST_LOOP;
                end else if (stat.opcode[15:12] == 4'hF && stat.opcode[7:0] == 8'h55) begin
                    loop_next = LP_SAVE; lim_next = {1'b0, stat.opcode[11:8]}; state_next = ST_LOOP;
                end else if (stat.opcode[15:12] == 4'hF && stat.opcode[7:0] == 8'h65) begin
                    loop_next = LP_LOAD; lim_next = {1'b0, stat.opcode[11:8]}; state_next = ST_LOOP;
                end else begin
                    ctl.cmd = DP_EXEC;
                end
            end
            ST_LOOP: begin
                ctl.idx = cnt_reg[4:0];
                case (loop_reg)
                    LP_CLEAR: ctl.cmd = DP_CLEAR_ROW;
                    LP_BCD: begin
                        mem_req.wr_en = 1'b1;
                        mem_req.addr = stat.index + cnt_reg;
                        mem_req.wdata = bcd;
                    end
                    LP_SAVE: begin
                        mem_req.wr_en = 1'b1;
                        mem_req.addr = stat.index + cnt_reg;
                        mem_req.wdata = stat.reg_k;
                    end
                    default: mem_req.addr = stat.index + cnt_reg;
                endcase
                if (loop_reg == LP_SPRITE || loop_reg == LP_LOAD) begin
                    state_next = ST_LOOPW;
                end else if (cnt_reg[4:0] == lim_reg) begin
                    state_next = ST_TICK;
                end else begin
                    cnt_next = cnt_reg + 12'd1;
                end
            end
            ST_LOOPW: begin
                // memory byte is now valid
                ctl.idx = cnt_reg[4:0];
                ctl.cmd = (loop_reg == LP_SPRITE) ? DP_SPR_ROW : DP_LOAD_REG;
                if (cnt_reg[4:0] == lim_reg) begin
                    state_next = (loop_reg == LP_SPRITE) ? ST_FWAIT : ST_TICK;
                end else begin
                    cnt_next = cnt_reg + 12'd1;
                    state_next = ST_LOOP;
                end
            end
            ST_FWAIT: begin
                ctl.cmd = DP_SPR_FLAG;
                state_next = ST_TICK;
            end
            ST_TICK: begin
                ctl.cmd = DP_TICK;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// File: sv/chip8_instruction_core_top.sv
`default_nettype none
// chip-8 core: one input word is a command (memory write, one instruction cycle, or screen
// row read; the unused command code is answered too) and gives one result word. each byte
// access goes through the single-port 4 KiB memory with registered read. s_tready rises
// again in the cycle after the result word is taken. after reset the memory is cleared and
// the font written before s_tready rises.
module chip8_instruction_core_top #(
    parameter int STACK_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // command[1:0], address[13:2], write_data[21:14], keys_down[37:22],
    // random_byte[45:38], row_select[50:46], zero fill
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // program_counter[11:0], last_opcode[27:12], waiting_for_key[28],
    // sound_on[29], screen_row[93:30], zero fill
    output logic [95:0]      m_tdata
);
    import c8_pkg::*;

    mem_req_t   mem_req;
    logic [7:0] mem_rdata;
    dp_ctl_t    ctl;
    dp_stat_t   stat;
    logic [11:0] pc;
    logic [15:0] op;
    logic        wt, snd;
    logic [63:0] row;

    c8_mem u_mem (.aclk(aclk), .req(mem_req), .rdata(mem_rdata));

    c8_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_fire(s_tvalid & s_tready), .s_ready(s_tready),
        .m_valid(m_tvalid), .m_ready(m_tready),
        .stat(stat), .mem_rdata(mem_rdata), .mem_req(mem_req), .ctl(ctl)
    );

    c8_datapath #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
        .in_command(s_tdata[1:0]), .in_address(s_tdata[13:2]),
        .in_write_data(s_tdata[21:14]), .in_keys(s_tdata[37:22]),
        .in_random(s_tdata[45:38]), .in_row(s_tdata[50:46]),
        .stat(stat), .pc_out(pc), .op_out(op), .wait_out(wt),
        .sound_out(snd), .row_out(row)
    );

    assign m_tdata = {2'd0, row, snd, wt, op, pc};
endmodule
`default_nettype wire

// File: sim/chip8_tb_pkg.sv
`timescale 1ns / 100ps
package chip8_tb_pkg;

    // command code that the core ignores
    localparam logic [1:0] CMD_NONE = 2'd3;

    // instruction groups, selected by the top nibble
    localparam logic [3:0] GRP_SYS    = 4'h0;
    localparam logic [3:0] GRP_JUMP   = 4'h1;
    localparam logic [3:0] GRP_CALL   = 4'h2;
    localparam logic [3:0] GRP_SEQ_K  = 4'h3;
    localparam logic [3:0] GRP_SNE_K  = 4'h4;
    localparam logic [3:0] GRP_SEQ_R  = 4'h5;
    localparam logic [3:0] GRP_LOAD_K = 4'h6;
    localparam logic [3:0] GRP_ADD_K  = 4'h7;
    localparam logic [3:0] GRP_ALU    = 4'h8;
    localparam logic [3:0] GRP_SNE_R  = 4'h9;
    localparam logic [3:0] GRP_SET_I  = 4'hA;
    localparam logic [3:0] GRP_JUMP_V = 4'hB;
    localparam logic [3:0] GRP_RAND   = 4'hC;
    localparam logic [3:0] GRP_DRAW   = 4'hD;
    localparam logic [3:0] GRP_KEY    = 4'hE;
    localparam logic [3:0] GRP_MISC   = 4'hF;

    localparam logic [15:0] OP_CLEAR  = 16'h00E0;
    localparam logic [15:0] OP_RETURN = 16'h00EE;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_RSB = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [7:0] KEY_SKIP_DOWN = 8'h9E;
    localparam logic [7:0] KEY_SKIP_UP   = 8'hA1;

    localparam logic [7:0] MISC_GET_DT  = 8'h07;
    localparam logic [7:0] MISC_KEYWAIT = 8'h0A;
    localparam logic [7:0] MISC_SET_DT  = 8'h15;
    localparam logic [7:0] MISC_SET_ST  = 8'h18;
    localparam logic [7:0] MISC_ADD_I   = 8'h1E;
    localparam logic [7:0] MISC_GLYPH   = 8'h29;
    localparam logic [7:0] MISC_BCD     = 8'h33;
    localparam logic [7:0] MISC_SAVE    = 8'h55;
    localparam logic [7:0] MISC_RESTORE = 8'h65;

endpackage

// File: sim/chip8_core_checker.sv
`timescale 1ns / 100ps
module chip8_core_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [55:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [95:0] m_tdata,
    output int               fail_count,
    output int               pending
);
    import c8_pkg::*;
    import chip8_tb_pkg::*;

    typedef struct packed {
        logic [63:0] row;
        logic        snd;
        logic        key_wait;
        logic [15:0] op;
        logic [11:0] pc;
    } core_result_t;

    localparam logic [7:0] FONT [0:79] = '{
        8'hF0,8'h90,8'h90,8'h90,8'hF0,8'h20,8'h60,8'h20,8'h20,8'h70,
        8'hF0,8'h10,8'hF0,8'h80,8'hF0,8'hF0,8'h10,8'hF0,8'h10,8'hF0,
        8'h90,8'h90,8'hF0,8'h10,8'h10,8'hF0,8'h80,8'hF0,8'h10,8'hF0,
        8'hF0,8'h80,8'hF0,8'h90,8'hF0,8'hF0,8'h10,8'h20,8'h40,8'h40,
        8'hF0,8'h90,8'hF0,8'h90,8'hF0,8'hF0,8'h90,8'hF0,8'h10,8'hF0,
        8'hF0,8'h90,8'hF0,8'h90,8'h90,8'hE0,8'h90,8'hE0,8'h90,8'hE0,
        8'hF0,8'h80,8'h80,8'h80,8'hF0,8'hE0,8'h90,8'h90,8'h90,8'hE0,
        8'hF0,8'h80,8'hF0,8'h80,8'hF0,8'hF0,8'h80,8'hF0,8'h80,8'h80};

    logic [7:0]  vreg [16];
    logic [7:0]  mem [4096];
    logic [11:0] idx_reg;
    logic [11:0] pc_reg;
    logic [11:0] ret_stack [16];
    logic [3:0]  sp;
    logic [7:0]  delay_t;
    logic [7:0]  sound_t;
    logic [63:0] frame [32];

    core_result_t expected_q [$];

    task automatic reset_machine();
        for (int i = 0; i < 4096; i++) mem[i] = 8'h00;
        for (int i = 0; i < 80; i++) mem[GLYPH_BASE + 12'(i)] = FONT[i];
        for (int i = 0; i < 16; i++) begin
            vreg[i] = 8'h00;
            ret_stack[i] = 12'h000;
        end
        for (int i = 0; i < 32; i++) frame[i] = 64'd0;
        idx_reg = 12'h000;
        pc_reg = PROGRAM_BASE;
        sp = 4'd0;
        delay_t = 8'h00;
        sound_t = 8'h00;
    endtask

    task automatic run_instruction(input logic [15:0] keys, input logic [7:0] rnd,
                                   output logic [15:0] op, output logic key_wait);
        logic [3:0]  x, y, n;
        logic [7:0]  kk, vx, vy;
        logic [11:0] nnn;
        logic [8:0]  sum;
        logic [63:0] spr;
        logic [5:0]  xp;
        logic [4:0]  row;
        logic        hit, found;
        op = {mem[pc_reg], mem[pc_reg + 12'd1]};
        x = op[11:8];
        y = op[7:4];
        n = op[3:0];
        kk = op[7:0];
        nnn = op[11:0];
        vx = vreg[x];
        vy = vreg[y];
        key_wait = 1'b0;
        pc_reg = pc_reg + 12'd2;
        case (op[15:12])
            GRP_SYS: begin
                if (op == OP_CLEAR) begin
                    for (int i = 0; i < 32; i++) frame[i] = 64'd0;
                end else if (op == OP_RETURN) begin
                    sp = sp - 4'd1;
                    pc_reg = ret_stack[sp];
                end
            end
            GRP_JUMP: pc_reg = nnn;
            GRP_CALL: begin
                ret_stack[sp] = pc_reg;
                sp = sp + 4'd1;
                pc_reg = nnn;
            end
            GRP_SEQ_K: if (vx == kk) pc_reg = pc_reg + 12'd2;
            GRP_SNE_K: if (vx != kk) pc_reg = pc_reg + 12'd2;
            GRP_SEQ_R: if (vx == vy) pc_reg = pc_reg + 12'd2;
            GRP_LOAD_K: vreg[x] = kk;
            GRP_ADD_K: vreg[x] = vx + kk;
            GRP_ALU: begin
                case (n)
                    ALU_MOV: vreg[x] = vy;
                    ALU_OR:  vreg[x] = vx | vy;
                    ALU_AND: vreg[x] = vx & vy;
                    ALU_XOR: vreg[x] = vx ^ vy;
                    ALU_ADD: begin
                        sum = {1'b0, vx} + {1'b0, vy};
                        vreg[x] = sum[7:0];
                        vreg[15] = {7'd0, sum[8]};
                    end
                    ALU_SUB: begin
                        vreg[x] = vx - vy;
                        vreg[15] = {7'd0, vx > vy};
                    end
                    ALU_SHR: begin
                        vreg[x] = vx >> 1;
                        vreg[15] = {7'd0, vx[0]};
                    end
                    ALU_RSB: begin
                        vreg[x] = vy - vx;
                        vreg[15] = {7'd0, vy > vx};
                    end
                    ALU_SHL: begin
                        vreg[x] = vx << 1;
                        vreg[15] = {7'd0, vx[7]};
                    end
                    default: ;
                endcase
            end
            GRP_SNE_R: if (vx != vy) pc_reg = pc_reg + 12'd2;
            GRP_SET_I: idx_reg = nnn;
            GRP_JUMP_V: pc_reg = nnn + {4'd0, vreg[0]};
            GRP_RAND: vreg[x] = rnd & kk;
            GRP_DRAW: begin
                xp = vx[5:0];
                hit = 1'b0;
                for (int r = 0; r < n; r++) begin
                    spr = {mem[idx_reg + 12'(r)], 56'd0};
                    if (xp != 6'd0) spr = (spr >> xp) | (spr << (7'd64 - {1'b0, xp}));
                    row = vy[4:0] + 5'(r);
                    if ((frame[row] & spr) != 64'd0) hit = 1'b1;
                    frame[row] = frame[row] ^ spr;
                end
                vreg[15] = {7'd0, hit};
            end
            GRP_KEY: begin
                if ((kk == KEY_SKIP_DOWN && keys[vx[3:0]]) ||
                    (kk == KEY_SKIP_UP && !keys[vx[3:0]]))
                    pc_reg = pc_reg + 12'd2;
            end
            default: begin
                case (kk)
                    MISC_GET_DT: vreg[x] = delay_t;
                    MISC_KEYWAIT: begin
                        found = 1'b0;
                        for (int k = 0; k < 16; k++) begin
                            if (keys[k] && !found) begin
                                found = 1'b1;
                                vreg[x] = 8'(k);
                            end
                        end
                        if (!found) begin
                            pc_reg = pc_reg - 12'd2;
                            key_wait = 1'b1;
                        end
                    end
                    MISC_SET_DT: delay_t = vx;
                    MISC_SET_ST: sound_t = vx;
                    MISC_ADD_I: idx_reg = idx_reg + {4'd0, vx};
                    MISC_GLYPH: idx_reg = GLYPH_BASE + 12'(vx[3:0]) * 12'd5;
                    MISC_BCD: begin
                        mem[idx_reg] = vx / 8'd100;
                        mem[idx_reg + 12'd1] = (vx / 8'd10) % 8'd10;
                        mem[idx_reg + 12'd2] = vx % 8'd10;
                    end
                    MISC_SAVE:
                        for (int k = 0; k <= x; k++) mem[idx_reg + 12'(k)] = vreg[k];
                    MISC_RESTORE:
                        for (int k = 0; k <= x; k++) vreg[k] = mem[idx_reg + 12'(k)];
                    default: ;
                endcase
            end
        endcase
        if (delay_t != 8'h00) delay_t = delay_t - 8'd1;
        if (sound_t != 8'h00) sound_t = sound_t - 8'd1;
    endtask

    task automatic apply_word(input logic [55:0] w, output core_result_t r);
        r = '0;
        case (w[1:0])
            CMD_WRITE: mem[w[13:2]] = w[21:14];
            CMD_EXEC:  run_instruction(w[37:22], w[45:38], r.op, r.key_wait);
            CMD_READ:  r.row = frame[w[50:46]];
            default: ;
        endcase
        r.pc = pc_reg;
        r.snd = (sound_t != 8'h00);
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
    end

    always @(posedge aclk) begin : watch
        core_result_t exp_r, got;
        if (!aresetn) begin
            reset_machine();
            expected_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                apply_word(s_tdata, exp_r);
                expected_q.push_back(exp_r);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[93:0];
                if (expected_q.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected result word pc=%h op=%h", got.pc, got.op);
                end else begin
                    exp_r = expected_q.pop_front();
                    if (got.pc !== exp_r.pc || got.op !== exp_r.op ||
                        got.key_wait !== exp_r.key_wait || got.snd !== exp_r.snd ||
                        got.row !== exp_r.row) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"mismatch exp pc=%h op=%h wait=%b snd=%b row=%h",
                                      " / got pc=%h op=%h wait=%b snd=%b row=%h"},
                                     exp_r.pc, exp_r.op, exp_r.key_wait, exp_r.snd, exp_r.row,
                                     got.pc, got.op, got.key_wait, got.snd, got.row);
                    end
                end
            end
        end
        pending <= expected_q.size();
    end

endmodule

// File: sim/tb_chip8_instruction_core_top.sv
`timescale 1ns / 100ps
module tb_chip8_instruction_core_top;
    import c8_pkg::*;
    import chip8_tb_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    int          fail_count;
    int          pending;
    int          cycle_count;
    int          results_seen;
    logic        send_calm;
    logic        recv_calm;

    chip8_instruction_core_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    chip8_core_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cycle_count = 0;
        results_seen = 0;
        send_calm = 1'b0;
        recv_calm = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, calm stretches, and one long hold-off to back up the core
    initial begin : result_side
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_calm = ~recv_calm;
            gap = recv_calm ? 0 : $urandom_range(0, 10);
            if (results_seen == 200) gap = 600;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            results_seen++;
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [11:0] addr,
                             input logic [7:0] wdata, input logic [15:0] keys,
                             input logic [7:0] rnd, input logic [4:0] row);
        int gap;
        if ($urandom_range(0, 39) == 0) send_calm = ~send_calm;
        gap = send_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, row, rnd, keys, wdata, addr, cmd};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic store_opcode(input logic [11:0] addr, input logic [15:0] op);
        send_word(CMD_WRITE, addr, op[15:8], 16'($urandom), 8'($urandom), 5'($urandom));
        send_word(CMD_WRITE, addr + 12'd1, op[7:0], 16'($urandom), 8'($urandom),
                  5'($urandom));
    endtask

    function automatic logic [15:0] pick_keys();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h0001 << $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    // random instruction whose direct jumps and calls stay inside the program window
    function automatic logic [15:0] pick_opcode();
        logic [3:0] grp, x, y;
        logic [7:0] kk;
        logic [7:0] misc_codes [10];
        grp = 4'($urandom);
        x = 4'($urandom);
        y = 4'($urandom);
        kk = 8'($urandom);
        misc_codes = '{MISC_GET_DT, MISC_KEYWAIT, MISC_SET_DT, MISC_SET_ST, MISC_ADD_I,
                       MISC_GLYPH, MISC_BCD, MISC_SAVE, MISC_RESTORE, kk};
        case (grp)
            GRP_SYS: begin
                case ($urandom_range(0, 3))
                    0: return OP_CLEAR;
                    1, 2: return OP_RETURN;
                    default: return {GRP_SYS, 12'($urandom)};
                endcase
            end
            GRP_JUMP, GRP_CALL:
                return {grp, PROGRAM_BASE + 12'($urandom_range(0, 63) * 2)};
            GRP_JUMP_V: return {grp, PROGRAM_BASE};
            GRP_SEQ_K, GRP_SNE_K:
                return {grp, x, $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : kk};
            GRP_KEY: begin
                case ($urandom_range(0, 4))
                    0: return {grp, x, kk};
                    1, 2: return {grp, x, KEY_SKIP_DOWN};
                    default: return {grp, x, KEY_SKIP_UP};
                endcase
            end
            GRP_MISC: return {grp, x, misc_codes[$urandom_range(0, 9)]};
            default: return {grp, x, y, 4'($urandom)};
        endcase
    endfunction

    initial begin : stimulus
        int pick;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // a call to itself, sixteen times, fills every return slot before any return runs
        store_opcode(PROGRAM_BASE, {GRP_CALL, PROGRAM_BASE});
        repeat (16) send_word(CMD_EXEC, 12'h000, 8'h00, 16'hFFFF, 8'hFF, 5'd0);
        send_word(CMD_WRITE, 12'hFFF, 8'hFF, 16'h0000, 8'h00, 5'd31);
        send_word(CMD_WRITE, 12'h000, 8'h00, 16'hFFFF, 8'hFF, 5'd0);
        send_word(CMD_READ, 12'hFFF, 8'hFF, 16'h0000, 8'h00, 5'd0);
        send_word(CMD_READ, 12'h000, 8'h00, 16'hFFFF, 8'hFF, 5'd31);
        send_word(CMD_NONE, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF, 5'd31);
        send_word(CMD_EXEC, 12'hFFF, 8'hFF, 16'h0000, 8'h00, 5'd31);

        // program window, closed off by a jump back to its start
        for (int a = 0; a < 128; a += 2)
            store_opcode(PROGRAM_BASE + 12'(a), pick_opcode());
        store_opcode(PROGRAM_BASE + 12'd128, {GRP_JUMP, PROGRAM_BASE});

        for (int round = 0; round < 8; round++) begin
            repeat (5)
                store_opcode(PROGRAM_BASE + 12'($urandom_range(0, 63) * 2), pick_opcode());
            repeat (100) begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_word(CMD_EXEC, 12'($urandom), 8'($urandom), pick_keys(),
                              8'($urandom), 5'($urandom));
                else if (pick < 88)
                    send_word(CMD_READ, 12'($urandom), 8'($urandom), 16'($urandom),
                              8'($urandom), 5'($urandom));
                else if (pick < 92)
                    send_word(CMD_NONE, 12'($urandom), 8'($urandom), 16'($urandom),
                              8'($urandom), 5'($urandom));
                else
                    send_word(CMD_WRITE, 12'($urandom), 8'($urandom), 16'($urandom),
                              8'($urandom), 5'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        // let the checker count the last accepted word before waiting on it
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: chip8_instruction_core_top.f
sv/c8_pkg.sv
sv/c8_mem.sv
sv/c8_datapath.sv
sv/c8_ctrl.sv
sv/chip8_instruction_core_top.sv
sim/chip8_tb_pkg.sv
sim/chip8_core_checker.sv
sim/tb_chip8_instruction_core_top.sv
